// ===== design/four_level_page_table_walker_core_assert.svh =====
// Assertion macros for the page table walker core.
// Sampled on aclk and held off while aresetn is low.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH

// Same-cycle implication.
`define PTW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("page table walker check failed");

// Next-cycle implication.
`define PTW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("page table walker check failed");

`endif

// ===== design/ptw_pkg.sv =====
// Shared types and constants for the page table walker.
// No dependencies.
package ptw_pkg;

    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int FRAME_W = 40;
    localparam int DATA_W  = 64;
    localparam int LVL_W   = 3;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2,
        KIND_PROTO = 2'd3
    } ptw_kind_t;

    // Classified word passed from the front to the back.
    typedef struct packed {
        logic               is_resp;
        logic [VA_W-1:0]    vaddr;
        logic [FRAME_W-1:0] frame;   // root frame for a request, entry[51:12] for a response
        logic               present;
        logic               big;
    } ptw_item_t;

    // Walk status reported by the back.
    typedef struct packed {
        logic       busy;
        logic [1:0] walk_level;
    } ptw_status_t;

endpackage

// ===== design/ptw_front.sv =====
// Front: accepts words from the input channel and classifies them.
// Depends on ptw_pkg.
module ptw_front import ptw_pkg::*; (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [VA_W-1:0]     s_virt_addr,
    input  logic [DATA_W-1:0]   s_read_data,
    input  logic [FRAME_W-1:0]  root_frame,
    input  logic                q_full,
    output logic                q_push,
    output ptw_item_t           q_item
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.is_resp = s_op;
        q_item.vaddr   = s_virt_addr;
        if (s_op) begin
            q_item.frame   = s_read_data[51:12];
            q_item.present = s_read_data[0];
            q_item.big     = s_read_data[7];
        end else begin
            q_item.frame   = root_frame;
            q_item.present = 1'b0;
            q_item.big     = 1'b0;
        end
    end

endmodule

// ===== design/ptw_queue.sv =====
// Short FIFO between front and back.
// Depends on ptw_pkg.
module ptw_queue import ptw_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  ptw_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output ptw_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ptw_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/ptw_back.sv =====
// Back: runs the walk state against queued words and drives the result register.
// Depends on ptw_pkg.
module ptw_back import ptw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  ptw_item_t         head_item,
    output logic              pop,
    output ptw_status_t       status,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_result_kind,
    output logic [PA_W-1:0]   m_address,
    output logic [LVL_W-1:0]  m_level
);

    logic             busy_reg, busy_next;
    logic [1:0]       wl_reg, wl_next;
    logic [VA_W-1:0]  sv_reg, sv_next;

    logic             m_valid_reg;
    ptw_kind_t        kind_reg, kind_next;
    logic [PA_W-1:0]  addr_reg, addr_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;

    logic [LVL_W-1:0] cur_lvl;
    logic [1:0]       wl_down;
    logic [8:0]       idx_down;

    assign pop = head_valid && (!m_valid_reg || m_ready);

    assign cur_lvl = {1'b0, wl_reg} + 3'd1;
    assign wl_down = wl_reg - 2'd1;

    // Index into the next table down, by the level being descended to
    always_comb begin
        case (wl_down)
            2'd2:    idx_down = sv_reg[38:30];
            2'd1:    idx_down = sv_reg[29:21];
            2'd0:    idx_down = sv_reg[20:12];
            default: idx_down = sv_reg[47:39];
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        wl_next   = wl_reg;
        sv_next   = sv_reg;
        kind_next = KIND_PROTO;
        addr_next = '0;
        lvl_next  = '0;
        if (!head_item.is_resp) begin
            if (!busy_reg) begin
                busy_next = 1'b1;
                wl_next   = 2'd3;
                sv_next   = head_item.vaddr;
                kind_next = KIND_READ;
                addr_next = {head_item.frame, head_item.vaddr[47:39], 3'b000};
                lvl_next  = 3'd4;
            end
        end else if (busy_reg) begin
            if (!head_item.present) begin
                busy_next = 1'b0;
                wl_next   = 2'd0;
                kind_next = KIND_FAULT;
                addr_next = {{(PA_W-VA_W){1'b0}}, sv_reg};
                lvl_next  = cur_lvl;
            end else if (cur_lvl == 3'd3 && head_item.big) begin
                busy_next = 1'b0;
                wl_next   = 2'd0;
                kind_next = KIND_DONE;
                addr_next = {head_item.frame[39:18], sv_reg[29:0]};
                lvl_next  = 3'd3;
            end else if (cur_lvl == 3'd2 && head_item.big) begin
                busy_next = 1'b0;
                wl_next   = 2'd0;
                kind_next = KIND_DONE;
                addr_next = {head_item.frame[39:9], sv_reg[20:0]};
                lvl_next  = 3'd2;
            end else if (cur_lvl == 3'd1) begin
                busy_next = 1'b0;
                wl_next   = 2'd0;
                kind_next = KIND_DONE;
                addr_next = {head_item.frame, sv_reg[11:0]};
                lvl_next  = 3'd1;
            end else begin
                // descend one level
                wl_next   = wl_down;
                kind_next = KIND_READ;
                addr_next = {head_item.frame, idx_down, 3'b000};
                lvl_next  = cur_lvl - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            wl_reg      <= 2'd0;
            sv_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                busy_reg <= busy_next;
                wl_reg   <= wl_next;
                sv_reg   <= sv_next;
            end
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg <= kind_next;
            addr_reg <= addr_next;
            lvl_reg  <= lvl_next;
        end
    end

    assign status.busy       = busy_reg;
    assign status.walk_level = wl_reg;

    assign m_valid       = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_address     = addr_reg;
    assign m_level       = lvl_reg;

endmodule

// ===== design/four_level_page_table_walker_core.sv =====
// Four-level page table walker core.
// Input channel (s_*): one word per handshake. s_op 0 starts a walk for
// s_virt_addr; s_op 1 returns the 64-bit entry read (s_read_data) for the
// walk in progress. Output channel (m_*): exactly one word per input word,
// in order: an entry read request (address and level 4..1), a finished
// translation, a not-present fault carrying the virtual address, or a
// protocol error (request while walking, response while idle).
// An accepted word lands in the queue and moves to the result register when
// that register is empty or m_ready is high. Throughput: one word per cycle
// while m_ready stays high, each word being one walk step in the back end;
// memory latency on the response path sets the pace of a walk.
// A two-word queue parts front and back, and the result register holds a
// word while m_ready is low; the queue fills and s_ready drops only after
// two more words. Reset (aresetn low, synchronous) empties the queue,
// drops m_valid, returns the walk to idle and clears root_frame.
// APB register 0 (byte address 0): root_frame, write only while idle.
// Depends on ptw_pkg, ptw_front, ptw_queue, ptw_back and four_level_page_table_walker_core_assert.svh.
`include "four_level_page_table_walker_core_assert.svh"

module four_level_page_table_walker_core import ptw_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [VA_W-1:0]     s_virt_addr,
    input  logic [DATA_W-1:0]   s_read_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_result_kind,
    output logic [PA_W-1:0]     m_address,
    output logic [LVL_W-1:0]    m_level
);

    logic [FRAME_W-1:0] root_frame_reg;
    logic               q_full;
    logic               q_push;
    ptw_item_t          q_item;
    logic               q_pop;
    logic               head_valid;
    ptw_item_t          head_item;
    ptw_status_t        status;
    logic               out_read;
    logic               out_end;
    logic               walk_top;
    logic               read_ok;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_frame_reg <= '0;
        end else if (psel && penable && pwrite && !paddr[3]) begin
            root_frame_reg <= pwdata[FRAME_W-1:0];
        end
    end

    assign prdata = paddr[3] ? 64'd0 : {{(64-FRAME_W){1'b0}}, root_frame_reg};

    ptw_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_virt_addr (s_virt_addr),
        .s_read_data (s_read_data),
        .root_frame  (root_frame_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_item)
    );

    ptw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    ptw_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (q_pop),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_address     (m_address),
        .m_level       (m_level)
    );

    assign out_read = m_valid && (m_result_kind == KIND_READ);
    assign out_end  = m_valid && (m_result_kind == KIND_DONE || m_result_kind == KIND_FAULT);
    assign walk_top = (m_level == 3'd4) && (status.walk_level == 2'd3);
    assign read_ok  = (m_address[2:0] == 3'b000) && (m_level != 3'd0) && (m_level <= 3'd4);

    `PTW_ASSERT_IMP(a_walk_start, $rose(status.busy), out_read && walk_top)
    `PTW_ASSERT_IMP(a_walk_end, $fell(status.busy), out_end)
    `PTW_ASSERT_IMP(a_read_aligned, out_read, read_ok)
    `PTW_ASSERT_NEXT(a_pop_loads, q_pop, m_valid)

endmodule

// ===== tb/four_level_page_table_walker_core_tb.sv =====
// Self-checking testbench for four_level_page_table_walker_core: directed walks,
// back-pressure and randomized walk traffic, checked against a built-in walk predictor.
// Depends on ptw_pkg and the core RTL.
module four_level_page_table_walker_core_tb;
    import ptw_pkg::*;

    localparam logic       OP_TRANSLATE  = 1'b0;
    localparam logic       OP_READ_RESP  = 1'b1;
    localparam logic [3:0] REG_ROOT_FRAME = 4'h0;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam logic [FRAME_W-1:0] ROOT_MAX = {FRAME_W{1'b1}};

    typedef struct {
        ptw_kind_t         kind;
        logic [PA_W-1:0]   addr;
        logic [LVL_W-1:0]  level;
    } walk_result_t;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    logic [VA_W-1:0]    s_virt_addr;
    logic [DATA_W-1:0]  s_read_data;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_result_kind;
    logic [PA_W-1:0]    m_address;
    logic [LVL_W-1:0]   m_level;

    // predictor state
    logic [FRAME_W-1:0] root_frame_q;
    logic               walk_busy;
    logic [1:0]         walk_lvl;
    logic [VA_W-1:0]    walk_va;

    walk_result_t pending_results[$];
    int mismatch_count = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int send_gap_pct = 0;
    int sink_stall_pct = 0;
    int sink_hold_req = 0;

    four_level_page_table_walker_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_virt_addr   (s_virt_addr),
        .s_read_data   (s_read_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_address     (m_address),
        .m_level       (m_level)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Table index for a level 4..1: bits 47:39, 38:30, 29:21 or 20:12.
    function automatic logic [8:0] va_slot(input logic [VA_W-1:0] va, input int lvl);
        va_slot = 9'(va >> (3 + 9 * lvl));
    endfunction

    // Advance the walk predictor by one accepted word and queue its result.
    task automatic walk_step(input logic op, input logic [VA_W-1:0] va,
                             input logic [DATA_W-1:0] entry);
        walk_result_t r;
        int lvl;
        r = '{KIND_PROTO, '0, '0};
        if (op == OP_TRANSLATE) begin
            if (!walk_busy) begin
                walk_busy = 1'b1;
                walk_lvl  = 2'd3;
                walk_va   = va;
                r = '{KIND_READ, {root_frame_q, va_slot(va, 4), 3'b000}, 3'd4};
            end
        end else if (walk_busy) begin
            lvl = int'(walk_lvl) + 1;
            if (!entry[0]) begin
                walk_busy = 1'b0;
                walk_lvl  = 2'd0;
                r = '{KIND_FAULT, {4'b0, walk_va}, 3'(lvl)};
            end else if (lvl == 3 && entry[7]) begin
                walk_busy = 1'b0;
                walk_lvl  = 2'd0;
                r = '{KIND_DONE, {entry[51:30], walk_va[29:0]}, 3'd3};
            end else if (lvl == 2 && entry[7]) begin
                walk_busy = 1'b0;
                walk_lvl  = 2'd0;
                r = '{KIND_DONE, {entry[51:21], walk_va[20:0]}, 3'd2};
            end else if (lvl == 1) begin
                walk_busy = 1'b0;
                walk_lvl  = 2'd0;
                r = '{KIND_DONE, {entry[51:12], walk_va[11:0]}, 3'd1};
            end else begin
                walk_lvl = walk_lvl - 2'd1;
                lvl = lvl - 1;
                r = '{KIND_READ, {entry[51:12], va_slot(walk_va, lvl), 3'b000}, 3'(lvl)};
            end
        end
        pending_results.push_back(r);
    endtask

    // Offer one word; call and return at a falling edge. Valid stays high on return.
    task automatic send_word(input logic op, input logic [VA_W-1:0] va,
                             input logic [DATA_W-1:0] entry);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_virt_addr <= va;
        s_read_data <= entry;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        walk_step(op, va, entry);
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [VA_W-1:0] rand_va();
        rand_va = VA_W'({$urandom, $urandom});
    endfunction

    // Random entry content with the present and big-page bits chosen separately.
    function automatic logic [DATA_W-1:0] rand_entry(input int present_pct, input int big_pct);
        logic [DATA_W-1:0] e;
        e = {$urandom, $urandom};
        e[0] = ($urandom_range(99) < present_pct);
        e[7] = ($urandom_range(99) < big_pct);
        rand_entry = e;
    endfunction

    // Close any open walk with a fault, drop valid and wait out every result.
    task automatic quiesce();
        if (walk_busy)
            send_word(OP_READ_RESP, '0, '0);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_root(input logic [FRAME_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ROOT_FRAME;
        pwdata  <= {24'b0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        root_frame_q = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Root frame still at its reset value: errors on both sides of a walk.
    task automatic test_protocol_errors();
        send_word(OP_READ_RESP, '0, {DATA_W{1'b1}});
        send_word(OP_TRANSLATE, {VA_W{1'b1}}, '0);
        send_word(OP_TRANSLATE, '0, {DATA_W{1'b1}});
        send_word(OP_READ_RESP, {VA_W{1'b1}}, '0);
        quiesce();
    endtask

    // Top of every range; big-page bit set at levels 4 and 1 must be ignored.
    task automatic test_full_walk();
        write_root(ROOT_MAX);
        send_word(OP_TRANSLATE, {VA_W{1'b1}}, '0);
        send_word(OP_READ_RESP, '0, {DATA_W{1'b1}});
        send_word(OP_READ_RESP, '0, ~64'h80);
        send_word(OP_READ_RESP, '0, ~64'h80);
        send_word(OP_READ_RESP, '0, {DATA_W{1'b1}});
        quiesce();
    endtask

    task automatic test_big_pages();
        write_root('0);
        send_word(OP_TRANSLATE, rand_va(), '0);
        send_word(OP_READ_RESP, '0, rand_entry(100, 0));
        send_word(OP_READ_RESP, '0, rand_entry(100, 100));
        send_word(OP_TRANSLATE, rand_va(), '0);
        send_word(OP_READ_RESP, '0, rand_entry(100, 100));
        send_word(OP_READ_RESP, '0, rand_entry(100, 0));
        send_word(OP_READ_RESP, '0, rand_entry(100, 100));
        quiesce();
    endtask

    // Not-present at levels 3, 2 and 1 (level 4 is covered above).
    task automatic test_fault_levels();
        write_root(FRAME_W'({$urandom, $urandom}));
        for (int depth = 1; depth <= 3; depth++) begin
            send_word(OP_TRANSLATE, rand_va(), '0);
            for (int i = 0; i < depth; i++)
                send_word(OP_READ_RESP, '0, rand_entry(100, 0));
            send_word(OP_READ_RESP, '0, rand_entry(0, 50));
        end
        quiesce();
    endtask

    // Hold the output off long enough that the queue fills and input stalls.
    task automatic test_backpressure();
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        sink_hold_req  = 300;
        for (int w = 0; w < 4; w++) begin
            send_word(OP_TRANSLATE, rand_va(), '0);
            while (walk_busy)
                send_word(OP_READ_RESP, '0, rand_entry(100, 0));
        end
        quiesce();
    endtask

    // Mostly well-formed walks with random content, plus stray words.
    task automatic run_random_phase(input int gap_pct, input int stall_pct, input int count);
        int stop_at;
        int next_cfg;
        logic [FRAME_W-1:0] root;
        send_gap_pct   = gap_pct;
        sink_stall_pct = stall_pct;
        stop_at  = items_sent + count;
        next_cfg = items_sent + 110;
        while (items_sent < stop_at) begin
            if (items_sent >= next_cfg) begin
                quiesce();
                case ($urandom_range(4))
                    0:       root = '0;
                    1:       root = ROOT_MAX;
                    default: root = FRAME_W'({$urandom, $urandom});
                endcase
                write_root(root);
                next_cfg = items_sent + 110;
            end
            if ($urandom_range(99) < 6) begin
                send_word(OP_READ_RESP, rand_va(), rand_entry(50, 50));
            end else begin
                send_word(OP_TRANSLATE, rand_va(), {$urandom, $urandom});
                while (walk_busy) begin
                    if ($urandom_range(99) < 5)
                        send_word(OP_TRANSLATE, rand_va(), {$urandom, $urandom});
                    else
                        send_word(OP_READ_RESP, rand_va(), rand_entry(90, 25));
                end
            end
        end
        quiesce();
    endtask

    // Output side: random stalls, or a long hold when one is requested.
    always @(negedge aclk) begin : sink_ctrl
        int hold_left;
        if (sink_hold_req > 0) begin
            hold_left = sink_hold_req;
            sink_hold_req = 0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        walk_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: kind %0d address %h level %0d",
                       m_result_kind, m_address, m_level);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, m_result_kind);
                    mismatch_count++;
                end
                if (m_address !== want.addr) begin
                    $error("address: expected %h, got %h", want.addr, m_address);
                    mismatch_count++;
                end
                if (m_level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, m_level);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("four_level_page_table_walker_core_tb: errors");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_op         = OP_TRANSLATE;
        s_virt_addr  = '0;
        s_read_data  = '0;
        root_frame_q = '0;
        walk_busy    = 1'b0;
        walk_lvl     = 2'd0;
        walk_va      = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_protocol_errors();
        test_full_walk();
        test_big_pages();
        test_fault_levels();
        test_backpressure();
        run_random_phase(17, 55, 340);
        run_random_phase(55, 17, 340);
        run_random_phase(0, 0, 340);

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("four_level_page_table_walker_core_tb: clean");
        else
            $display("four_level_page_table_walker_core_tb: errors");
        $finish;
    end

endmodule
